### rtl/core/psi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psi_pkg
// Shared widths, register indexes and saturation helpers for the PID step
// with shrink-only integration.
// ---------------------------------------------------------------------------
package psi_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic signed [DATA_WIDTH-1:0]   t_data;
    typedef logic signed [DATA_WIDTH:0]     t_data_x1;
    typedef logic signed [DATA_WIDTH+1:0]   t_data_x2;
    typedef logic signed [2*DATA_WIDTH-1:0] t_prod;
    typedef logic        [DATA_WIDTH-2:0]   t_limit;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd3;

    localparam t_data  DATA_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data  DATA_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_limit LIMIT_MAX = {(DATA_WIDTH-1){1'b1}};

    // Saturate a value one bit wider than the data word.
    function automatic t_data sat_x1(input t_data_x1 v);
        t_data res;
        if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
            res = v[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end else begin
            res = v[DATA_WIDTH-1:0];
        end
        return res;
    endfunction

    // Saturate a value two bits wider than the data word.
    function automatic t_data sat_x2(input t_data_x2 v);
        t_data res;
        if (v[DATA_WIDTH+1:DATA_WIDTH-1] != {3{v[DATA_WIDTH+1]}}) begin
            res = v[DATA_WIDTH+1] ? DATA_MIN : DATA_MAX;
        end else begin
            res = v[DATA_WIDTH-1:0];
        end
        return res;
    endfunction

    // Scale a full product back by the fraction bits (floor) and saturate.
    function automatic t_data sat_prod(input t_prod p);
        t_prod sh;
        t_data res;
        sh = p >>> FRAC_BITS;
        if (sh[2*DATA_WIDTH-1:DATA_WIDTH-1] != {(DATA_WIDTH+1){sh[2*DATA_WIDTH-1]}}) begin
            res = sh[2*DATA_WIDTH-1] ? DATA_MIN : DATA_MAX;
        end else begin
            res = sh[DATA_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/pid_shrink_integral_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_shrink_integral_unit
// One PID step per transaction in signed fixed point, with an integral that
// adds the error on each mode's first step, later only on a sign mismatch.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ----------------------------
//  in        sink       i_in_valid / o_in_ready    i_mode, i_target, i_sample_value
//  out       source     o_out_valid / i_out_ready  o_drive, o_p_term, o_i_term, o_d_term
//  cfg       sink       i_cfg_we (always taken)    i_cfg_idx, i_cfg_data
//
//  One transaction per cycle sustained while the output is not stalled. The
//  error, integral and derivative are settled in the accept cycle and held
//  in the first stage, the second stage holds the three products, and the
//  third scales, saturates and sums them into the output register.
//  Each stage holds when the stage after it is full and stalled, so a stall
//  on the output reaches the input only once all three stages are full.
//  Reset (synchronous, active low) empties the pipeline, clears the gains,
//  the integral, the previous error and the first-step flags, and sets the
//  integral limit to its maximum.
// ---------------------------------------------------------------------------
module pid_shrink_integral_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [psi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [psi_pkg::DATA_WIDTH-1:0]       i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mode,
    input  logic signed [psi_pkg::DATA_WIDTH-1:0] i_target,
    input  logic signed [psi_pkg::DATA_WIDTH-1:0] i_sample_value,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [psi_pkg::DATA_WIDTH-1:0] o_drive,
    output logic signed [psi_pkg::DATA_WIDTH-1:0] o_p_term,
    output logic signed [psi_pkg::DATA_WIDTH-1:0] o_i_term,
    output logic signed [psi_pkg::DATA_WIDTH-1:0] o_d_term
);

    localparam int DW = psi_pkg::DATA_WIDTH;

    // configuration registers
    psi_pkg::t_data  r_gain_p;
    psi_pkg::t_data  r_gain_i;
    psi_pkg::t_data  r_gain_d;
    psi_pkg::t_limit r_limit;

    // controller state
    psi_pkg::t_data  r_integral;
    psi_pkg::t_data  r_prev_err;
    logic [1:0]      r_first_done;

    // pipeline
    logic            r_v1;
    logic            r_v2;
    logic            r_v3;
    psi_pkg::t_data  r_s1_err;
    psi_pkg::t_data  r_s1_int;
    psi_pkg::t_data  r_s1_der;
    psi_pkg::t_prod  r_s2_p;
    psi_pkg::t_prod  r_s2_i;
    psi_pkg::t_prod  r_s2_d;
    psi_pkg::t_data  r_drive;
    psi_pkg::t_data  r_p_term;
    psi_pkg::t_data  r_i_term;
    psi_pkg::t_data  r_d_term;

    logic            rdy1;
    logic            rdy2;
    logic            rdy3;
    logic            in_acc;

    psi_pkg::t_data    n_err;
    psi_pkg::t_data    n_integral;
    psi_pkg::t_data    n_deriv;
    psi_pkg::t_data_x1 diff_err;
    psi_pkg::t_data_x1 diff_der;
    psi_pkg::t_data_x1 int_sum;
    psi_pkg::t_data_x1 int_pick;
    psi_pkg::t_data_x1 lim_pos;
    psi_pkg::t_data_x1 lim_neg;
    logic              sign_differs;
    logic              add_en;

    psi_pkg::t_data    p_sat;
    psi_pkg::t_data    i_sat;
    psi_pkg::t_data    d_sat;
    psi_pkg::t_data_x2 term_sum;

    assign rdy3       = !r_v3 || i_out_ready;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = rdy1;
    assign in_acc     = i_in_valid && rdy1;

    // error, integral update and derivative for the transaction being accepted
    always_comb begin
        diff_err = {i_target[DW-1], i_target} - {i_sample_value[DW-1], i_sample_value};
        n_err    = i_mode ? i_sample_value : psi_pkg::sat_x1(diff_err);

        // sign of -1/0/+1 differs when the negative or the zero flag differs
        sign_differs = (n_err[DW-1] != r_integral[DW-1]) ||
                       ((n_err == '0) != (r_integral == '0));
        add_en   = !r_first_done[i_mode] || sign_differs;
        int_sum  = {r_integral[DW-1], r_integral} + {n_err[DW-1], n_err};
        int_pick = add_en ? int_sum : {r_integral[DW-1], r_integral};

        lim_pos  = {2'b00, r_limit};
        lim_neg  = -lim_pos;
        if (int_pick > lim_pos) begin
            n_integral = lim_pos[DW-1:0];
        end else if (int_pick < lim_neg) begin
            n_integral = lim_neg[DW-1:0];
        end else begin
            n_integral = int_pick[DW-1:0];
        end

        diff_der = {n_err[DW-1], n_err} - {r_prev_err[DW-1], r_prev_err};
        n_deriv  = psi_pkg::sat_x1(diff_der);
    end

    // scale, saturate and sum the products
    always_comb begin
        p_sat    = psi_pkg::sat_prod(r_s2_p);
        i_sat    = psi_pkg::sat_prod(r_s2_i);
        d_sat    = psi_pkg::sat_prod(r_s2_d);
        term_sum = {{2{p_sat[DW-1]}}, p_sat} + {{2{i_sat[DW-1]}}, i_sat} +
                   {{2{d_sat[DW-1]}}, d_sat};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_limit  <= psi_pkg::LIMIT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psi_pkg::REG_GAIN_P: r_gain_p <= i_cfg_data;
                psi_pkg::REG_GAIN_I: r_gain_i <= i_cfg_data;
                psi_pkg::REG_GAIN_D: r_gain_d <= i_cfg_data;
                psi_pkg::REG_LIMIT:  r_limit  <= i_cfg_data[DW-2:0];
                default: ;
            endcase
        end
    end

    // controller state advances on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_prev_err   <= '0;
            r_first_done <= '0;
        end else if (in_acc) begin
            r_integral           <= n_integral;
            r_prev_err           <= n_err;
            r_first_done[i_mode] <= 1'b1;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_err <= n_err;
            r_s1_int <= n_integral;
            r_s1_der <= n_deriv;
        end
        if (rdy2 && r_v1) begin
            r_s2_p <= psi_pkg::t_prod'(r_gain_p) * psi_pkg::t_prod'(r_s1_err);
            r_s2_i <= psi_pkg::t_prod'(r_gain_i) * psi_pkg::t_prod'(r_s1_int);
            r_s2_d <= psi_pkg::t_prod'(r_gain_d) * psi_pkg::t_prod'(r_s1_der);
        end
        if (rdy3 && r_v2) begin
            r_p_term <= p_sat;
            r_i_term <= i_sat;
            r_d_term <= d_sat;
            r_drive  <= psi_pkg::sat_x2(term_sum);
        end
    end

    assign o_out_valid = r_v3;
    assign o_drive     = r_drive;
    assign o_p_term    = r_p_term;
    assign o_i_term    = r_i_term;
    assign o_d_term    = r_d_term;

    // the clamp keeps the integral off the most negative code
    a_integral_not_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integral != psi_pkg::DATA_MIN)
        else $error("integral reached the most negative code");

    // an accepted transaction marks its mode's first step as taken
    a_first_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_mode) |=> r_first_done[0])
        else $error("first-step flag for measured mode not set");

    a_first_flag_set_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode) |=> r_first_done[1])
        else $error("first-step flag for direct mode not set");

    // an accepted transaction lands in the first stage
    a_stage1_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("accepted transaction missing from first stage");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for pid_shrink_integral_unit. A directed table covers
// the field extremes, both modes, the first step of each mode, zero errors
// and saturation; random steps under random gain settings follow. Every
// transaction is predicted in the bench, and each result is checked field
// by field, with random stalls on both channels.
// ---------------------------------------------------------------------------
module tb;

    localparam longint WORD_MAX = (longint'(1) <<< (psi_pkg::DATA_WIDTH - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam psi_pkg::t_data ONE_Q = psi_pkg::t_data'(1) <<< psi_pkg::FRAC_BITS;

    typedef struct {
        psi_pkg::t_data drive;
        psi_pkg::t_data p_term;
        psi_pkg::t_data i_term;
        psi_pkg::t_data d_term;
    } t_pid_terms;

    typedef struct {
        int unsigned    grp;
        logic           mode;
        psi_pkg::t_data target;
        psi_pkg::t_data sample;
        bit             fixed;
        t_pid_terms     want;
    } t_step_row;

    typedef struct {
        psi_pkg::t_data gain_p;
        psi_pkg::t_data gain_i;
        psi_pkg::t_data gain_d;
        psi_pkg::t_data limit;
    } t_gain_set;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [psi_pkg::CFG_IDX_W-1:0]  i_cfg_idx      = psi_pkg::REG_GAIN_P;
    logic [psi_pkg::DATA_WIDTH-1:0] i_cfg_data     = '0;
    logic                           i_in_valid     = 1'b0;
    logic                           o_in_ready;
    logic                           i_mode         = 1'b0;
    psi_pkg::t_data                 i_target       = '0;
    psi_pkg::t_data                 i_sample_value = '0;
    logic                           o_out_valid;
    logic                           i_out_ready    = 1'b0;
    psi_pkg::t_data                 o_drive;
    psi_pkg::t_data                 o_p_term;
    psi_pkg::t_data                 o_i_term;
    psi_pkg::t_data                 o_d_term;

    // Predictor state and its copy of the registers
    longint kp, ki, kd, integ_limit, integ, last_err;
    bit     first_meas, first_direct;

    t_pid_terms pid_terms_q[$];
    t_step_row  dir_rows[$];
    int         n_errors, n_steps, n_checked, n_sets;
    bit         steady;

    pid_shrink_integral_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_target       (i_target),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_drive        (o_drive),
        .o_p_term       (o_p_term),
        .o_i_term       (o_i_term),
        .o_d_term       (o_d_term)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clip_word(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Full product, floor shift back to the fixed-point scale, then saturate
    function automatic longint scaled_product(longint gain, longint operand);
        longint full;
        full = gain * operand;
        return clip_word(full >>> psi_pkg::FRAC_BITS);
    endfunction

    function automatic t_pid_terms compute_pid_terms(logic mode, psi_pkg::t_data tgt,
                                                     psi_pkg::t_data smp);
        longint     err, p, i, d;
        t_pid_terms r;
        err = mode ? longint'(smp) : clip_word(longint'(tgt) - longint'(smp));
        // First step of each mode always integrates; later ones only on a sign mismatch
        if (mode ? !first_direct : !first_meas) begin
            integ = integ + err;
            if (mode) first_direct = 1'b1;
            else first_meas = 1'b1;
        end else if (sign_of(err) != sign_of(integ)) begin
            integ = integ + err;
        end
        if (integ > integ_limit) integ = integ_limit;
        else if (integ < -integ_limit) integ = -integ_limit;
        p = scaled_product(kp, err);
        i = scaled_product(ki, integ);
        d = scaled_product(kd, clip_word(err - last_err));
        last_err = err;
        r.drive  = psi_pkg::t_data'(clip_word(p + i + d));
        r.p_term = psi_pkg::t_data'(p);
        r.i_term = psi_pkg::t_data'(i);
        r.d_term = psi_pkg::t_data'(d);
        return r;
    endfunction

    function automatic psi_pkg::t_data rand_data();
        case ($urandom_range(9))
            0: return psi_pkg::DATA_MIN;
            1: return psi_pkg::DATA_MAX;
            2: return '0;
            3: return $urandom_range(1) ? psi_pkg::t_data'(1) : psi_pkg::t_data'(-1);
            4, 5, 6: return psi_pkg::t_data'(int'($urandom_range(1 << 21)) - (1 << 20));
            default: return psi_pkg::t_data'($urandom);
        endcase
    endfunction

    function automatic psi_pkg::t_data rand_gain();
        case ($urandom_range(7))
            0: return psi_pkg::DATA_MIN;
            1: return psi_pkg::DATA_MAX;
            2: return '0;
            3: return ONE_Q;
            4, 5: return psi_pkg::t_data'(int'($urandom_range(1 << 19)) - (1 << 18));
            default: return psi_pkg::t_data'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [psi_pkg::CFG_IDX_W-1:0] idx, psi_pkg::t_data data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            psi_pkg::REG_GAIN_P: kp = longint'(data);
            psi_pkg::REG_GAIN_I: ki = longint'(data);
            psi_pkg::REG_GAIN_D: kd = longint'(data);
            psi_pkg::REG_LIMIT:  integ_limit = longint'(data[psi_pkg::DATA_WIDTH-2:0]);
            default: ;
        endcase
    endtask

    task automatic apply_gains(t_gain_set gs);
        write_reg(psi_pkg::REG_GAIN_P, gs.gain_p);
        write_reg(psi_pkg::REG_GAIN_I, gs.gain_i);
        write_reg(psi_pkg::REG_GAIN_D, gs.gain_d);
        write_reg(psi_pkg::REG_LIMIT, gs.limit);
        i_cfg_we <= 1'b0;
        n_sets++;
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pid_terms_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_step(logic mode, psi_pkg::t_data tgt, psi_pkg::t_data smp,
                             bit fixed, t_pid_terms want);
        t_pid_terms predicted;
        if (!steady) begin
            while ($urandom_range(99) < 27) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_target       <= tgt;
        i_sample_value <= smp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = compute_pid_terms(mode, tgt, smp);
        pid_terms_q.push_back(fixed ? want : predicted);
        n_steps++;
    endtask

    task automatic add_row(int unsigned grp, logic mode, psi_pkg::t_data tgt,
                           psi_pkg::t_data smp, bit fixed = 1'b0);
        t_step_row row;
        row.grp    = grp;
        row.mode   = mode;
        row.target = tgt;
        row.sample = smp;
        row.fixed  = fixed;
        row.want   = '{drive: '0, p_term: '0, i_term: '0, d_term: '0};
        dir_rows.push_back(row);
    endtask

    task automatic check_field(string name, psi_pkg::t_data want, psi_pkg::t_data got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 27);
    end

    always @(posedge i_clk) begin
        t_pid_terms w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pid_terms_q.size() == 0) begin
                $display("%0t: result with none expected, actual drive %0d", $time, o_drive);
                n_errors++;
            end else begin
                w = pid_terms_q.pop_front();
                n_checked++;
                check_field("drive", w.drive, o_drive);
                check_field("p_term", w.p_term, o_p_term);
                check_field("i_term", w.i_term, o_i_term);
                check_field("d_term", w.d_term, o_d_term);
            end
        end
    end

    initial begin
        t_gain_set      dir_gains[5];
        t_gain_set      gs;
        t_step_row      row;
        int unsigned    cur_grp;
        logic           m;
        psi_pkg::t_data tg, sm;

        kp          = 0;
        ki          = 0;
        kd          = 0;
        integ_limit = longint'(psi_pkg::LIMIT_MAX);
        integ       = 0;
        last_err    = 0;
        first_meas   = 1'b0;
        first_direct = 1'b0;
        steady      = 1'b0;

        dir_gains[1] = '{ONE_Q, ONE_Q, ONE_Q, 32'sh0005_0000};
        dir_gains[2] = '{psi_pkg::DATA_MIN, psi_pkg::DATA_MIN, psi_pkg::DATA_MAX, '0};
        dir_gains[3] = '{psi_pkg::DATA_MAX, psi_pkg::DATA_MAX, psi_pkg::DATA_MAX,
                         psi_pkg::DATA_MAX};
        dir_gains[4] = '{32'sh0000_8000, -ONE_Q, 32'sd3, 32'sh0000_7fff};

        // Reset gains are zero, so every term reads zero while the first
        // step of each mode loads the integral
        add_row(0, 1'b0, psi_pkg::DATA_MAX, psi_pkg::DATA_MIN, 1'b1);
        add_row(0, 1'b1, '0, psi_pkg::DATA_MIN, 1'b1);
        add_row(0, 1'b0, psi_pkg::DATA_MIN, psi_pkg::DATA_MAX, 1'b1);
        add_row(0, 1'b1, psi_pkg::DATA_MAX, '0, 1'b1);
        // Unit gains, small limit: shrink only, zero error, clamping
        add_row(1, 1'b1, '0, 32'sh0003_0000);
        add_row(1, 1'b1, '0, 32'sh0003_0000);
        add_row(1, 1'b0, 32'sh0001_0000, 32'sh0009_0000);
        add_row(1, 1'b0, -32'sd5, -32'sd5);
        add_row(1, 1'b1, '0, psi_pkg::DATA_MAX);
        add_row(1, 1'b1, '0, psi_pkg::DATA_MIN);
        add_row(1, 1'b0, psi_pkg::DATA_MAX, psi_pkg::DATA_MIN);
        add_row(1, 1'b0, '0, '0);
        // Extreme gains, zero limit: saturated products
        add_row(2, 1'b1, '0, psi_pkg::DATA_MAX);
        add_row(2, 1'b1, psi_pkg::DATA_MIN, psi_pkg::DATA_MIN);
        add_row(2, 1'b0, psi_pkg::DATA_MIN, psi_pkg::DATA_MIN);
        add_row(2, 1'b1, '0, 32'sd1);
        add_row(2, 1'b1, '0, -32'sd1);
        // Largest gains and limit: saturated sum, floor of negative products
        add_row(3, 1'b1, '0, psi_pkg::DATA_MAX);
        add_row(3, 1'b1, '0, psi_pkg::DATA_MIN);
        add_row(3, 1'b0, 32'sh0001_2345, -32'sh0000_6789);
        add_row(3, 1'b1, '0, -32'sd1);
        // Fractional gains: rounding towards minus infinity
        add_row(4, 1'b1, '0, 32'sd3);
        add_row(4, 1'b1, '0, -32'sd3);
        add_row(4, 1'b0, -32'sh40, 32'sh40);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cur_grp = 0;
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.grp != cur_grp) begin
                settle();
                apply_gains(dir_gains[row.grp]);
                cur_grp = row.grp;
            end
            send_step(row.mode, row.target, row.sample, row.fixed, row.want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            gs.gain_p = rand_gain();
            gs.gain_i = rand_gain();
            gs.gain_d = rand_gain();
            case ($urandom_range(4))
                0: gs.limit = '0;
                1: gs.limit = {1'($urandom_range(1)), psi_pkg::LIMIT_MAX};
                2: gs.limit = psi_pkg::t_data'($urandom_range(1 << 20));
                default: gs.limit = psi_pkg::t_data'($urandom);
            endcase
            apply_gains(gs);
            // One phase runs with no idling on either side
            steady = (ph == 3);
            for (int n = 0; n < 212; n++) begin
                m  = 1'($urandom_range(1));
                tg = rand_data();
                if (!m && $urandom_range(1))
                    sm = tg - psi_pkg::t_data'(int'($urandom_range(1 << 17)) - (1 << 16));
                else
                    sm = rand_data();
                send_step(m, tg, sm, 1'b0, '{drive: '0, p_term: '0, i_term: '0, d_term: '0});
            end
            steady = 1'b0;
        end

        settle();
        $display("Ran %0d PID steps under %0d gain settings (plus the reset setting).",
                 n_steps, n_sets);
        $display("Checked %0d results, %0d field mismatches.", n_checked, n_errors);
        if (n_errors == 0 && pid_terms_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", pid_terms_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### pid_shrink_integral_unit.f
rtl/core/psi_pkg.sv
rtl/core/pid_shrink_integral_unit.sv
bench/tb.sv
